/* rtl/core/oewm_pkg.sv */
// Shared types and constants for the eight-op word machine executor.
`default_nettype none

package oewm_pkg;

  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PC_W      = 16;
  localparam int unsigned OFF_W     = 16;
  localparam int unsigned OP_LSB    = 22;
  localparam int unsigned RA_LSB    = 19;
  localparam int unsigned RB_LSB    = 16;

  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_STEP = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NAND = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_RSVD = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_MEMRD,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        load_addr;
    logic signed [31:0] load_data;
  } in_req_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic [2:0]         executed_op;
    logic               reg_written;
    logic [2:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [15:0]        mem_addr;
    logic signed [31:0] mem_data;
    logic [31:0]        retired_count;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic decode;
    logic exec;
    logic writeback;
    logic pass;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t            op;
    logic               halted;
    logic [MEM_AW-1:0]  pc;
    logic [WORD_W-1:0]  retired;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/oewm_ctrl.sv */
// Controller state machine that sequences fetch, decode, execute and delivery.
`default_nettype none

module oewm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  input  oewm_pkg::dp_sts_t sts,
  output oewm_pkg::dp_cmd_t cmd
);
  import oewm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == ITEM_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_DONE;
          end else if (sts.halted) begin
            cmd.pass  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            cmd.fetch = 1'b1;
            state_nxt = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (sts.op == OP_LW) ? ST_MEMRD : ST_DONE;
      end
      ST_MEMRD: begin
        cmd.writeback = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free or drains now.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/oewm_dp.sv */
// Datapath: word memory, register file, program counter, ALU and result registers.
`default_nettype none

module oewm_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  oewm_pkg::dp_cmd_t  cmd,
  input  oewm_pkg::in_req_t  in_data,
  output oewm_pkg::dp_sts_t  sts,
  output oewm_pkg::out_rsp_t out_data
);
  import oewm_pkg::*;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] mem_rdata_r;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [WORD_W-1:0]    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [WORD_W-1:0]    rf_a_r, rf_b_r;
  logic                 rf_we;
  logic [REG_AW-1:0]    rf_widx;
  logic [WORD_W-1:0]    rf_wdata;

  logic [WORD_W-1:0] instr_r;
  logic [MEM_AW-1:0] pc_r;
  logic              halted_r;
  logic [WORD_W-1:0] retired_r;
  out_rsp_t          res_r, res_nxt;
  out_rsp_t          out_r;

  logic [REG_AW-1:0] dec_ra, dec_rb;
  opcode_t           op;
  logic [REG_AW-1:0] rb, dst;
  logic [WORD_W-1:0] off, alu_val, daddr32, npc32;
  logic [MEM_AW-1:0] daddr;
  logic              beq_take;

  // Register addresses come straight from the fetched word during decode.
  assign dec_ra = mem_rdata_r[RA_LSB +: REG_AW];
  assign dec_rb = mem_rdata_r[RB_LSB +: REG_AW];

  assign op       = opcode_t'(instr_r[OP_LSB +: 3]);
  assign rb       = instr_r[RB_LSB +: REG_AW];
  assign dst      = instr_r[REG_AW-1:0];
  assign off      = {{(WORD_W-OFF_W){instr_r[OFF_W-1]}}, instr_r[OFF_W-1:0]};
  assign alu_val  = (op == OP_ADD) ? (rf_a_r + rf_b_r) : ~(rf_a_r & rf_b_r);
  assign daddr32  = rf_a_r + off;
  assign daddr    = daddr32[MEM_AW-1:0];
  assign beq_take = (op == OP_BEQ) && (rf_a_r == rf_b_r);
  assign npc32    = WORD_W'(pc_r) + WORD_W'(1) + (beq_take ? off : '0);

  // One write port and one read port on the word memory.
  assign mem_we    = cmd.load || (cmd.exec && (op == OP_SW));
  assign mem_waddr = cmd.load ? in_data.load_addr[MEM_AW-1:0] : daddr;
  assign mem_wdata = cmd.load ? in_data.load_data : rf_b_r;
  assign mem_re    = cmd.fetch || (cmd.exec && (op == OP_LW));
  assign mem_raddr = cmd.fetch ? pc_r : daddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign rf_we    = (cmd.exec && ((op == OP_ADD) || (op == OP_NAND))) || cmd.writeback;
  assign rf_widx  = cmd.writeback ? rb : dst;
  assign rf_wdata = cmd.writeback ? mem_rdata_r : alu_val;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_widx] <= rf_wdata;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      instr_r <= mem_rdata_r;
      rf_a_r  <= rf_vld_r[dec_ra] ? rf_mem[dec_ra] : '0;
      rf_b_r  <= rf_vld_r[dec_rb] ? rf_mem[dec_rb] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      halted_r  <= 1'b0;
      retired_r <= '0;
    end else if (cmd.exec) begin
      pc_r      <= npc32[MEM_AW-1:0];
      halted_r  <= halted_r || (op == OP_HALT);
      retired_r <= retired_r + WORD_W'(1);
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.load || cmd.pass) begin
      res_nxt               = '0;
      res_nxt.next_pc       = PC_W'(pc_r);
      res_nxt.halted        = halted_r;
      res_nxt.retired_count = retired_r;
    end else if (cmd.exec) begin
      res_nxt               = '0;
      res_nxt.next_pc       = PC_W'(npc32[MEM_AW-1:0]);
      res_nxt.halted        = halted_r || (op == OP_HALT);
      res_nxt.executed_op   = op;
      res_nxt.retired_count = retired_r + WORD_W'(1);
      case (op)
        OP_ADD, OP_NAND: begin
          res_nxt.reg_written = 1'b1;
          res_nxt.reg_index   = dst;
          res_nxt.reg_value   = alu_val;
        end
        OP_LW: begin
          // The loaded value is filled in on the writeback cycle.
          res_nxt.reg_written = 1'b1;
          res_nxt.reg_index   = rb;
        end
        OP_SW: begin
          res_nxt.mem_written = 1'b1;
          res_nxt.mem_addr    = PC_W'(daddr);
          res_nxt.mem_data    = rf_b_r;
        end
        default: begin
        end
      endcase
    end else if (cmd.writeback) begin
      res_nxt.reg_value = mem_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_data    = out_r;
  assign sts.op      = op;
  assign sts.halted  = halted_r;
  assign sts.pc      = pc_r;
  assign sts.retired = retired_r;

endmodule

`default_nettype wire

/* rtl/core/eight_op_word_machine_executor_core.sv */
// Top level of the eight-op word machine executor: controller, datapath and checks.
`default_nettype none

// A small word-addressed machine with eight 32-bit registers, a 65536-word memory
// and a program counter. A load request writes one memory word; a step request
// fetches the word at pc and executes add, nand, lw, sw, beq, halt or noop, and
// each request returns exactly one result. Requests are handled one at a time:
// a load request, or a step after halt, goes straight to the done state, an
// instruction passes through decode and execute, and lw adds a memory-read
// state, because the single read port of the word memory serves first the
// fetch and then the load data, with a registered register-file read between
// them. A new request is accepted while the previous result still waits in the
// output register. Memory contents are undefined after reset and there is no
// clearing pass; a program must be loaded before it is stepped. Registers, pc,
// halt flag and the retired count are cleared by reset.
module eight_op_word_machine_executor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  oewm_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output oewm_pkg::out_rsp_t out_data
);
  import oewm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  oewm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.opcode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  oewm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  // Once halted, the machine stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(sts.halted) |-> sts.halted)
    else $error("halt flag cleared without reset");

  // The retired count only ever advances by one.
  a_retired_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (sts.retired != $past(sts.retired))
      |-> sts.retired == $past(sts.retired) + 32'd1)
    else $error("retired count jumped");

  // The pc moves only on an execute cycle.
  a_pc_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cmd.exec) |-> sts.pc == $past(sts.pc))
    else $error("pc changed outside execute");
`endif

endmodule

`default_nettype wire

/* tb/eight_op_word_machine_executor_core_tb.sv */
// Self-checking testbench for the eight-op word machine executor core.
module eight_op_word_machine_executor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oewm_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  // Machine state as predicted from the accepted requests.
  logic [31:0] mach_mem [0:MEM_WORDS-1];
  bit          mem_loaded [0:MEM_WORDS-1];
  logic [31:0] mach_regs [0:REG_COUNT-1];
  logic [15:0] mach_pc = '0;
  bit          mach_halted = 1'b0;
  logic [31:0] mach_retired = '0;

  in_req_t  pend_q [$];
  out_rsp_t pending_rsp_q [$];
  out_rsp_t rsp_want;
  int       sent = 0;
  int       accepted = 0;
  int       errors = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       req_taken = 1'b0;
  bit       calm_in = 1'b0;
  bit       calm_out = 1'b0;

  eight_op_word_machine_executor_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic execute_item(input in_req_t req, output out_rsp_t rsp);
    logic [31:0] word;
    logic [31:0] offs;
    logic [31:0] npc;
    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [15:0] addr;
    opcode_t     op;
    rsp = '0;
    if (req.opcode == ITEM_LOAD) begin
      addr = 16'(req.load_addr % MEM_WORDS);
      mach_mem[addr] = req.load_data;
      mem_loaded[addr] = 1'b1;
    end else if (!mach_halted) begin
      word  = mach_mem[mach_pc];
      op    = opcode_t'(word[OP_LSB +: 3]);
      a_val = mach_regs[word[RA_LSB +: 3]];
      b_val = mach_regs[word[RB_LSB +: 3]];
      offs  = {{16{word[15]}}, word[15:0]};
      npc   = {16'd0, mach_pc} + 32'd1;
      rsp.executed_op = op;
      case (op)
        OP_ADD, OP_NAND: begin
          rsp.reg_written = 1'b1;
          rsp.reg_index   = word[2:0];
          rsp.reg_value   = (op == OP_ADD) ? a_val + b_val : ~(a_val & b_val);
        end
        OP_LW: begin
          rsp.reg_written = 1'b1;
          rsp.reg_index   = word[RB_LSB +: 3];
          addr            = 16'((a_val + offs) % MEM_WORDS);
          rsp.reg_value   = mach_mem[addr];
        end
        OP_SW: begin
          rsp.mem_written = 1'b1;
          rsp.mem_addr    = 16'((a_val + offs) % MEM_WORDS);
          rsp.mem_data    = b_val;
          mach_mem[rsp.mem_addr]   = b_val;
          mem_loaded[rsp.mem_addr] = 1'b1;
        end
        OP_BEQ: begin
          if (a_val == b_val) npc = npc + offs;
        end
        OP_HALT: begin
          mach_halted = 1'b1;
        end
        default: ;
      endcase
      if (rsp.reg_written) mach_regs[rsp.reg_index] = rsp.reg_value;
      mach_pc = 16'(npc % MEM_WORDS);
      mach_retired = mach_retired + 32'd1;
    end
    rsp.next_pc       = mach_pc;
    rsp.halted        = mach_halted;
    rsp.retired_count = mach_retired;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Request driver: a new request may only replace one that has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (pend_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pause_len(calm_in);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      execute_item(in_data, rsp_want);
      pending_rsp_q.push_back(rsp_want);
      req_taken = 1'b1;
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request outstanding, expected none, got %h",
                 $time, out_data);
      end else begin
        rsp_want = pending_rsp_q.pop_front();
        check_field("next_pc", 32'(rsp_want.next_pc), 32'(out_data.next_pc));
        check_field("halted", 32'(rsp_want.halted), 32'(out_data.halted));
        check_field("executed_op", 32'(rsp_want.executed_op), 32'(out_data.executed_op));
        check_field("reg_written", 32'(rsp_want.reg_written), 32'(out_data.reg_written));
        check_field("reg_index", 32'(rsp_want.reg_index), 32'(out_data.reg_index));
        check_field("reg_value", rsp_want.reg_value, out_data.reg_value);
        check_field("mem_written", 32'(rsp_want.mem_written), 32'(out_data.mem_written));
        check_field("mem_addr", 32'(rsp_want.mem_addr), 32'(out_data.mem_addr));
        check_field("mem_data", rsp_want.mem_data, out_data.mem_data);
        check_field("retired_count", rsp_want.retired_count, out_data.retired_count);
      end
      stall_left = pause_len(calm_out);
    end
  end

  task automatic send(input in_req_t req);
    pend_q.push_back(req);
    sent++;
    if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
    if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
    wait (accepted == sent);
  endtask

  task automatic load_word(input logic [15:0] addr, input logic [31:0] data);
    in_req_t req;
    req.opcode    = ITEM_LOAD;
    req.load_addr = addr;
    req.load_data = data;
    send(req);
  endtask

  // The address and data fields of a step request are don't-care, so fill them anyway.
  task automatic step_machine();
    in_req_t req;
    req.opcode    = ITEM_STEP;
    req.load_addr = 16'($urandom);
    req.load_data = $urandom;
    send(req);
  endtask

  function automatic logic [31:0] make_instr(opcode_t op, logic [2:0] ra, logic [2:0] rb,
                                             logic [15:0] low);
    return {7'($urandom), op, ra, rb, low};
  endfunction

  function automatic logic [31:0] random_instr();
    opcode_t     op;
    logic [15:0] low;
    op = opcode_t'($urandom_range(0, 6));
    if (op == OP_HALT) op = OP_NOOP;
    low = $urandom_range(0, 1) ? 16'($urandom_range(0, 16) - 8) : 16'($urandom);
    return make_instr(op, 3'($urandom), 3'($urandom), low);
  endfunction

  // Makes sure the fetch, and the load data of an lw, only touch written words,
  // and keeps a halt out of the way until the end of the run.
  task automatic guarded_step();
    logic [31:0] word;
    logic [31:0] addr;
    if (!mem_loaded[mach_pc] || mach_mem[mach_pc][OP_LSB +: 3] == OP_HALT ||
        $urandom_range(0, 7) == 0)
      load_word(mach_pc, random_instr());
    word = mach_mem[mach_pc];
    if (word[OP_LSB +: 3] == OP_LW) begin
      addr = (mach_regs[word[RA_LSB +: 3]] + {{16{word[15]}}, word[15:0]}) % MEM_WORDS;
      if (!mem_loaded[addr]) load_word(addr[15:0], $urandom);
    end
    step_machine();
  endtask

  initial begin : stimulus
    int pick;
    int run_len;
    int next_drain;
    for (int r = 0; r < REG_COUNT; r++) mach_regs[r] = '0;
    next_drain = 350;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Short program touching every opcode but halt, with wrapping addresses
    // and both extreme branch offsets.
    load_word(16'hFFFF, 32'h7FFF_FFFF);
    load_word(16'd0, make_instr(OP_NAND, 3'd0, 3'd0, 16'd1));
    load_word(16'd1, make_instr(OP_ADD, 3'd1, 3'd1, 16'd7));
    load_word(16'd2, make_instr(OP_LW, 3'd0, 3'd3, 16'hFFFF));
    load_word(16'd3, make_instr(OP_LW, 3'd1, 3'd4, 16'd1));
    load_word(16'd4, make_instr(OP_SW, 3'd1, 3'd3, 16'hFFFF));
    load_word(16'd5, make_instr(OP_ADD, 3'd3, 3'd3, 16'd0));
    load_word(16'd6, make_instr(OP_RSVD, 3'($urandom), 3'($urandom), 16'($urandom)));
    load_word(16'd7, make_instr(OP_NOOP, 3'($urandom), 3'($urandom), 16'($urandom)));
    load_word(16'd8, make_instr(OP_BEQ, 3'd1, 3'd1, 16'd1));
    load_word(16'd10, make_instr(OP_BEQ, 3'd0, 3'd1, 16'h8000));
    load_word(16'd11, make_instr(OP_BEQ, 3'd5, 3'd6, 16'h8000));
    load_word(16'd32780, make_instr(OP_BEQ, 3'd2, 3'd2, 16'h7FFF));
    load_word(16'd12, make_instr(OP_NAND, 3'd3, 3'd3, 16'd0));
    repeat (13) step_machine();

    while (sent < 1400) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_word(16'($urandom), $urandom);
      end else if (pick < 13) begin
        run_len = $urandom_range(2, 6);
        for (int k = 1; k <= run_len; k++) load_word(16'(mach_pc + k), random_instr());
      end else begin
        guarded_step();
      end
      if (sent >= next_drain) begin
        wait (pending_rsp_q.size() == 0);
        next_drain += 350;
      end
    end

    // Halt is sticky, so it only comes once every other case has been run.
    wait (pending_rsp_q.size() == 0);
    load_word(mach_pc, make_instr(OP_HALT, 3'($urandom), 3'($urandom), 16'($urandom)));
    repeat (3) step_machine();
    load_word(16'($urandom), $urandom);
    step_machine();

    wait (pending_rsp_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* eight_op_word_machine_executor_core.f */
rtl/core/oewm_pkg.sv
rtl/core/oewm_ctrl.sv
rtl/core/oewm_dp.sv
rtl/core/eight_op_word_machine_executor_core.sv
tb/eight_op_word_machine_executor_core_tb.sv
